// ===== sv/opd_pkg.sv =====
// ----------------------------------------------------------------------------
// opd_pkg: shared types and constants for the OOK/PWM pulse decoder
// Field widths, register codes, decoder modes and the structs passed
// between the configuration, front, queue and back units.
// ----------------------------------------------------------------------------
`default_nettype none

package opd_pkg;

  // Payload field widths
  localparam int DurW    = 16;
  localparam int ShortW  = 14;
  localparam int LongW   = 16;
  localparam int PctW    = 7;
  localparam int TargetW = 7;
  localparam int ProtoW  = 8;
  localparam int CodeW   = 64;
  localparam int LenW    = 7;

  // Longest code held in the shift register
  localparam int MaxCodeBits = 64;
  localparam logic [CodeW-1:0] CodeMask = {CodeW{1'b1}} >> (CodeW - MaxCodeBits);

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // Tolerance math: tol = nominal * pct / 100, divide by reciprocal multiply
  localparam int Percent  = 100;
  localparam int ProdSW   = ShortW + PctW;
  localparam int ProdLW   = LongW + PctW;
  localparam int TolSW    = 15;
  localparam int TolLW    = 17;
  localparam int DivShift = 30;
  localparam int RecipW   = 24;
  localparam logic [RecipW-1:0] DivRecip =
    RecipW'(((2 ** DivShift) + Percent - 1) / Percent);

  // Width for duration compares (covers 4x short and 4x short tolerance)
  localparam int CmpW = 17;

  // Reset values of the registers
  localparam logic [ShortW-1:0]  ShortReset  = ShortW'(330);
  localparam logic [LongW-1:0]   LongReset   = LongW'(660);
  localparam logic [PctW-1:0]    PctReset    = PctW'(25);
  localparam logic [TargetW-1:0] TargetReset = TargetW'(40);
  localparam logic [ProtoW-1:0]  ProtoReset  = '0;

  // Cycles from a register write until the tolerances are valid again
  localparam logic [1:0] SettleCycles = 2'd2;

  // Input queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    RegShortTime = 3'd0,
    RegLongTime  = 3'd1,
    RegTolPct    = 3'd2,
    RegTarget    = 3'd3,
    RegProtocol  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ModeHunt   = 2'd0,
    ModeData   = 2'd1,
    ModeIgnore = 2'd2
  } mode_t;

  // Timing settings seen by the classifier
  typedef struct packed {
    logic [ShortW-1:0] short_time;
    logic [LongW-1:0]  long_time;
    logic [TolSW-1:0]  tol_s;
    logic [TolLW-1:0]  tol_l;
  } timing_t;

  // Settings seen by the decoder back end
  typedef struct packed {
    logic [TargetW-1:0] target;
    logic [ProtoW-1:0]  protocol;
  } frame_cfg_t;

  // Classified pulse pair
  typedef struct packed {
    logic start;
    logic bit0;
    logic bit1;
    logic last;
  } pair_class_t;

  function automatic logic [CmpW-1:0] abs_diff(logic [CmpW-1:0] a, logic [CmpW-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

// ===== sv/opd_cfg.sv =====
// ----------------------------------------------------------------------------
// opd_cfg: register file and tolerance pipeline
// Holds the five settings and derives the short and long tolerances in
// two registered steps (product, then reciprocal divide by 100).
// ----------------------------------------------------------------------------
`default_nettype none

module opd_cfg (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [opd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [opd_pkg::CfgDataW-1:0] cfg_data,
  output opd_pkg::timing_t         timing,
  output opd_pkg::frame_cfg_t      frame_cfg,
  output logic                     settled
);
  import opd_pkg::*;

  logic [ShortW-1:0]  short_time;
  logic [LongW-1:0]   long_time;
  logic [PctW-1:0]    tol_pct;
  logic [TargetW-1:0] target_bits;
  logic [ProtoW-1:0]  protocol;
  logic [1:0]         settle;

  logic [ProdSW-1:0] prod_s;
  logic [ProdLW-1:0] prod_l;
  logic [TolSW-1:0]  tol_s;
  logic [TolLW-1:0]  tol_l;

  logic [ProdSW+RecipW-1:0] quot_s_full;
  logic [ProdLW+RecipW-1:0] quot_l_full;
  logic                     wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_time  <= ShortReset;
      long_time   <= LongReset;
      tol_pct     <= PctReset;
      target_bits <= TargetReset;
      protocol    <= ProtoReset;
    end else if (wr) begin
      unique case (cfg_reg_t'(cfg_index))
        RegShortTime: short_time  <= cfg_data[ShortW-1:0];
        RegLongTime:  long_time   <= cfg_data[LongW-1:0];
        RegTolPct:    tol_pct     <= cfg_data[PctW-1:0];
        RegTarget:    target_bits <= cfg_data[TargetW-1:0];
        RegProtocol:  protocol    <= cfg_data[ProtoW-1:0];
        default: ;
      endcase
    end
  end

  // Items are held off until the tolerances reflect the latest write
  always_ff @(posedge clk) begin
    if (rst || wr) begin
      settle <= SettleCycles;
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  assign settled = (settle == 2'd0);

  assign quot_s_full = (ProdSW+RecipW)'(prod_s) * (ProdSW+RecipW)'(DivRecip);
  assign quot_l_full = (ProdLW+RecipW)'(prod_l) * (ProdLW+RecipW)'(DivRecip);

  always_ff @(posedge clk) begin
    prod_s <= ProdSW'(short_time) * ProdSW'(tol_pct);
    prod_l <= ProdLW'(long_time) * ProdLW'(tol_pct);
    tol_s  <= quot_s_full[DivShift +: TolSW];
    tol_l  <= quot_l_full[DivShift +: TolLW];
  end

  assign timing.short_time = short_time;
  assign timing.long_time  = long_time;
  assign timing.tol_s      = tol_s;
  assign timing.tol_l      = tol_l;

  assign frame_cfg.target   = (target_bits > TargetW'(MaxCodeBits)) ?
                              TargetW'(MaxCodeBits) : target_bits;
  assign frame_cfg.protocol = protocol;

endmodule

`default_nettype wire

// ===== sv/opd_front.sv =====
// ----------------------------------------------------------------------------
// opd_front: pulse pair classifier
// Matches one high/low pair against the start, bit-0 and bit-1 shapes.
// ----------------------------------------------------------------------------
`default_nettype none

module opd_front (
  input  logic [opd_pkg::DurW-1:0] high_time,
  input  logic [opd_pkg::DurW-1:0] low_time,
  input  logic                     last_pair,
  input  opd_pkg::timing_t         timing,
  output opd_pkg::pair_class_t     pair_class
);
  import opd_pkg::*;

  logic [CmpW-1:0] hi, lo, s, l, s4, ts, tl, ts4;
  logic            hi_start, hi_short, hi_long, lo_short, lo_long;

  assign hi  = CmpW'(high_time);
  assign lo  = CmpW'(low_time);
  assign s   = CmpW'(timing.short_time);
  assign l   = CmpW'(timing.long_time);
  assign s4  = CmpW'({timing.short_time, 2'b00});
  assign ts  = CmpW'(timing.tol_s);
  assign tl  = CmpW'(timing.tol_l);
  assign ts4 = CmpW'({timing.tol_s, 2'b00});

  assign hi_start = abs_diff(hi, s4) < ts4;
  assign hi_short = abs_diff(hi, s)  < ts;
  assign hi_long  = abs_diff(hi, l)  < tl;
  assign lo_short = abs_diff(lo, s)  < ts;
  assign lo_long  = abs_diff(lo, l)  < tl;

  assign pair_class.start = hi_start && lo_short;
  assign pair_class.bit0  = hi_short && lo_long;
  assign pair_class.bit1  = hi_long  && lo_short;
  assign pair_class.last  = last_pair;

endmodule

`default_nettype wire

// ===== sv/opd_queue.sv =====
// ----------------------------------------------------------------------------
// opd_queue: classified pair FIFO
// Small register FIFO between classifier and decoder back end.
// ----------------------------------------------------------------------------
`default_nettype none

module opd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  opd_pkg::pair_class_t push_data,
  output logic                 full,
  input  logic                 pop,
  output opd_pkg::pair_class_t pop_data,
  output logic                 empty
);
  import opd_pkg::*;

  pair_class_t      mem [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;

  assign full     = (count == QCntW'(QDepth));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      if (push && !pop) begin
        count <= count + QCntW'(1);
      end else if (pop && !push) begin
        count <= count - QCntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/opd_back.sv =====
// ----------------------------------------------------------------------------
// opd_back: frame decoder and result register
// Tracks hunt/data/ignore mode, shifts in bits and issues results.
// ----------------------------------------------------------------------------
`default_nettype none

module opd_back (
  input  logic                         clk,
  input  logic                         rst,
  input  opd_pkg::frame_cfg_t          frame_cfg,
  input  logic                         q_empty,
  input  opd_pkg::pair_class_t         q_data,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         decode_ok,
  output logic [opd_pkg::CodeW-1:0]    decoded_code,
  output logic [opd_pkg::LenW-1:0]     bit_length,
  output logic [opd_pkg::ProtoW-1:0]   protocol_id
);
  import opd_pkg::*;

  mode_t           mode, mode_mid, mode_next;
  logic [CodeW-1:0] code, code_mid, code_next;
  logic [LenW-1:0]  cnt, cnt_mid, cnt_next, cnt_inc;
  logic             emit, emit_ok, is_bit;

  assign is_bit  = q_data.bit0 || q_data.bit1;
  assign cnt_inc = cnt + LenW'(1);
  assign q_pop   = !q_empty && (!out_valid || out_ready);

  // Next mode
  always_comb begin
    mode_mid = mode;
    unique case (mode)
      ModeHunt: begin
        if (q_data.start) begin
          mode_mid = (frame_cfg.target == '0) ? ModeIgnore : ModeData;
        end
      end
      ModeData: begin
        if (!is_bit || (cnt_inc >= LenW'(frame_cfg.target))) begin
          mode_mid = ModeIgnore;
        end
      end
      default: ;
    endcase
    mode_next = q_data.last ? ModeHunt : mode_mid;
  end

  // Datapath and result
  always_comb begin
    code_mid = code;
    cnt_mid  = cnt;
    emit     = 1'b0;
    emit_ok  = 1'b0;
    unique case (mode)
      ModeHunt: begin
        if (q_data.start) begin
          code_mid = '0;
          cnt_mid  = '0;
          if (frame_cfg.target == '0) begin
            emit    = 1'b1;
            emit_ok = 1'b1;
          end
        end
      end
      ModeData: begin
        if (is_bit) begin
          code_mid = {code[CodeW-2:0], q_data.bit1} & CodeMask;
          cnt_mid  = cnt_inc;
          if (cnt_inc >= LenW'(frame_cfg.target)) begin
            emit    = 1'b1;
            emit_ok = 1'b1;
          end
        end else begin
          emit = 1'b1;
        end
      end
      default: ;
    endcase
    // capture ended without a decision
    if (q_data.last && !emit && (mode_mid == ModeHunt || mode_mid == ModeData)) begin
      emit = 1'b1;
    end
    code_next = q_data.last ? '0 : code_mid;
    cnt_next  = q_data.last ? '0 : cnt_mid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ModeHunt;
      code <= '0;
      cnt  <= '0;
    end else if (q_pop) begin
      mode <= mode_next;
      code <= code_next;
      cnt  <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      decode_ok    <= emit_ok;
      decoded_code <= emit_ok ? code_mid : '0;
      bit_length   <= emit_ok ? cnt_mid : '0;
      protocol_id  <= frame_cfg.protocol;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ook_pwm_pulse_decoder.sv =====
// Path: the pair that decides a result reaches out_valid through the queue,
//   then the result register, and waits in the queue while it backs up behind a stall.
// Throughput: one pulse pair per cycle while in_ready is high; the 4-entry queue
//   and the result register let input and output stall independently.
// Reset and register writes: in_ready stays low until the tolerance pipeline
//   has settled; reset also returns configuration to defaults.
// ----------------------------------------------------------------------------
// ook_pwm_pulse_decoder: OOK/PWM remote pulse width decoder
// Classifies high/low duration pairs against configured short/long times
// and assembles them into a code, reporting success or failure per capture.
// ----------------------------------------------------------------------------
`default_nettype none

module ook_pwm_pulse_decoder (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [opd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [opd_pkg::CfgDataW-1:0]  cfg_data,
  // pulse pair input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [opd_pkg::DurW-1:0]      high_time,
  input  logic [opd_pkg::DurW-1:0]      low_time,
  input  logic                          last_pair,
  // decode result output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          decode_ok,
  output logic [opd_pkg::CodeW-1:0]     decoded_code,
  output logic [opd_pkg::LenW-1:0]      bit_length,
  output logic [opd_pkg::ProtoW-1:0]    protocol_id
);
  import opd_pkg::*;

  timing_t     timing;
  frame_cfg_t  frame_cfg;
  logic        settled;
  pair_class_t pair_class;
  pair_class_t q_data;
  logic        q_full, q_empty, q_pop, push;

  // Settings and derived tolerances
  opd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .timing    (timing),
    .frame_cfg (frame_cfg),
    .settled   (settled)
  );

  // Front end: classify each pair as it is transferred in
  opd_front u_front (
    .high_time  (high_time),
    .low_time   (low_time),
    .last_pair  (last_pair),
    .timing     (timing),
    .pair_class (pair_class)
  );

  // Accept while there is queue room and the tolerances are current
  assign in_ready = !q_full && settled;
  assign push     = in_valid && in_ready;

  opd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (pair_class),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  // Back end: decode state and result register
  opd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .frame_cfg    (frame_cfg),
    .q_empty      (q_empty),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .decode_ok    (decode_ok),
    .decoded_code (decoded_code),
    .bit_length   (bit_length),
    .protocol_id  (protocol_id)
  );

endmodule

`default_nettype wire
